// ===== rtl/core/cpa_pkg.sv =====
package cpa_pkg;

  // Sizing of the allocator.
  localparam int NUM_PORTS    = 8;
  localparam int NUM_STATIONS = 4;
  localparam int WEIGHT_BITS  = 32;

  // The capable-port mask is eight bits wide, so at most eight ports take part.
  localparam int MASK_BITS  = 8;
  localparam int PORT_W     = 3;
  localparam int PORT_LIMIT = (NUM_PORTS < MASK_BITS) ? NUM_PORTS : MASK_BITS;
  localparam int ST_W       = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;

  // Counter widths.
  localparam int SLOT_W  = 8;
  localparam int STALL_W = 24;
  localparam int CYC_W   = 16;
  localparam logic [STALL_W-1:0] STALL_MAX = {STALL_W{1'b1}};
  localparam logic [SLOT_W-1:0]  SLOT_MAX  = {SLOT_W{1'b1}};

  // Transaction kinds.
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_ISSUE   = 2'd1;
  localparam logic [1:0] KIND_DEALLOC = 2'd2;
  localparam logic [1:0] KIND_TICK    = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_PORT_MAP = 2'd0;
  localparam logic [1:0] REG_CAPACITY = 2'd1;
  localparam logic [1:0] REG_DISPATCH = 2'd2;

  // Register reset values.
  localparam logic [15:0] MAP_RESET      = 16'hFA50;
  localparam logic [31:0] CAPACITY_RESET = 32'h10101010;
  localparam logic [31:0] DISPATCH_RESET = 32'h02020202;

  // One port's bid into the selection tree.
  typedef struct packed {
    logic                   req;
    logic                   ok;
    logic [STALL_W-1:0]     stall;
    logic [SLOT_W-1:0]      space;
    logic [WEIGHT_BITS-1:0] weight;
    logic [PORT_W-1:0]      port;
  } cand_t;

  // Outcome of one selection.
  typedef struct packed {
    logic              any;
    logic              have;
    logic [PORT_W-1:0] best;
  } pick_t;

  // Station that a port feeds; an out-of-range station number wraps.
  function automatic logic [ST_W-1:0] station_of(input logic [15:0] map,
                                                 input logic [PORT_W-1:0] port);
    logic [1:0] s;
    s = map[{port, 1'b0} +: 2];
    return ST_W'(s % NUM_STATIONS);
  endfunction

endpackage

// ===== rtl/core/cpa_select.sv =====
module cpa_select (
  input  cpa_pkg::cand_t [cpa_pkg::MASK_BITS-1:0] cands,
  output cpa_pkg::pick_t                          pick
);
  import cpa_pkg::*;

  // Heap-ordered tournament: nodes 1..7 are winners, 8..15 the leaves.
  cand_t node [1:2*MASK_BITS-1];
  logic [PORT_W-1:0] first_port;
  logic              any_req;

  // On a full tie the lower-indexed (left) entrant stays, as in a linear scan.
  function automatic logic right_wins(input cand_t a, input cand_t b);
    logic r;
    if (!b.ok) begin
      r = 1'b0;
    end else if (!a.ok) begin
      r = 1'b1;
    end else if (b.stall != a.stall) begin
      r = b.stall < a.stall;
    end else if (b.space != a.space) begin
      r = b.space > a.space;
    end else begin
      r = b.weight < a.weight;
    end
    return r;
  endfunction

  genvar g;
  generate
    for (g = 0; g < MASK_BITS; g++) begin : g_leaf
      assign node[MASK_BITS + g] = cands[g];
    end
    for (g = MASK_BITS - 1; g >= 1; g--) begin : g_node
      assign node[g] = right_wins(node[2*g], node[2*g+1]) ? node[2*g+1] : node[2*g];
    end
  endgenerate

  // Fallback: lowest requesting port.
  always_comb begin
    first_port = '0;
    any_req    = 1'b0;
    for (int i = MASK_BITS - 1; i >= 0; i--) begin
      if (cands[i].req) begin
        first_port = PORT_W'(i);
        any_req    = 1'b1;
      end
    end
  end

  assign pick.any  = any_req;
  assign pick.have = node[1].ok;
  assign pick.best = node[1].ok ? node[1].port : first_port;

endmodule

// ===== rtl/core/capacity_aware_port_allocator_core.sv =====
// Channel        | Ports                                            | Handshake
// ---------------+--------------------------------------------------+---------------------------
// Request        | in_kind, in_capable_ports, in_target_port,       | start high, busy low
//                | in_stall_cycles                                  |
// Result         | out_chosen_port, out_found_free, out_error       | out_valid, one cycle
// Configuration  | psel, penable, pwrite, paddr, pwdata, prdata     | APB, pready always high
//
// A transaction is captured in the input register and its result appears in the cycle after,
// for one cycle, with out_valid; one transaction is taken every cycle.
// The port selection tree plus the counter update sit between the input register and the
// result and state registers.
// busy stays low; the receiver cannot stall the result path.
// rst_n is synchronous and active low; it clears all counters and weights and loads the
// register reset values.
module capacity_aware_port_allocator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_kind,
  input  logic [cpa_pkg::MASK_BITS-1:0]   in_capable_ports,
  input  logic [cpa_pkg::PORT_W-1:0]      in_target_port,
  input  logic [cpa_pkg::CYC_W-1:0]       in_stall_cycles,
  output logic                            out_valid,
  output logic [cpa_pkg::PORT_W-1:0]      out_chosen_port,
  output logic                            out_found_free,
  output logic                            out_error,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import cpa_pkg::*;

  // Configuration registers.
  logic [15:0] map_r;
  logic [31:0] cap_r;
  logic [31:0] rate_r;
  logic        cfg_wr;

  // Input register.
  logic                 req_v_r;
  logic [1:0]           kind_r;
  logic [MASK_BITS-1:0] mask_r;
  logic [PORT_W-1:0]    tgt_r;
  logic [CYC_W-1:0]     stall_r;

  // Allocator state.
  logic [SLOT_W-1:0]      slots_r    [NUM_STATIONS];
  logic [SLOT_W-1:0]      slots_nxt  [NUM_STATIONS];
  logic [STALL_W-1:0]     stall_r2   [NUM_STATIONS];
  logic [STALL_W-1:0]     stall_nxt  [NUM_STATIONS];
  logic [SLOT_W-1:0]      disp_r     [NUM_STATIONS];
  logic [SLOT_W-1:0]      disp_nxt   [NUM_STATIONS];
  logic [WEIGHT_BITS-1:0] weight_r   [NUM_PORTS];
  logic [WEIGHT_BITS-1:0] weight_nxt [NUM_PORTS];

  // Per-station status.
  logic              st_ok    [NUM_STATIONS];
  logic [SLOT_W-1:0] st_space [NUM_STATIONS];
  logic              st_empty [NUM_STATIONS];
  logic              st_under [NUM_STATIONS];

  cand_t [MASK_BITS-1:0] cands;
  pick_t                 pick;

  logic [ST_W-1:0] best_st;
  logic [ST_W-1:0] tgt_st;
  logic            tgt_ok;
  logic            is_alloc;
  logic            is_rel;
  logic            is_tick;
  logic            alloc_go;
  logic            rel_err;
  logic            rel_go;

  // Configuration port: zero-wait writes and reads.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_PORT_MAP: prdata = {16'd0, map_r};
      REG_CAPACITY: prdata = cap_r;
      REG_DISPATCH: prdata = rate_r;
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r  <= MAP_RESET;
      cap_r  <= CAPACITY_RESET;
      rate_r <= DISPATCH_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PORT_MAP: map_r  <= pwdata[15:0];
        REG_CAPACITY: cap_r  <= pwdata;
        REG_DISPATCH: rate_r <= pwdata;
        default: ;
      endcase
    end
  end

  // A new transaction is taken every cycle.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else begin
      req_v_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      kind_r  <= in_kind;
      mask_r  <= in_capable_ports;
      tgt_r   <= in_target_port;
      stall_r <= in_stall_cycles;
    end
  end

  // Station status: free slot, dispatch budget, and release checks.
  genvar gs, gp;
  generate
    for (gs = 0; gs < NUM_STATIONS; gs++) begin : g_st
      logic [SLOT_W-1:0] cap_b;
      logic [SLOT_W-1:0] rate_b;
      assign cap_b  = cap_r[8*(gs%4) +: 8];
      assign rate_b = rate_r[8*(gs%4) +: 8];
      assign st_ok[gs]    = (slots_r[gs] < cap_b) && (disp_r[gs] < rate_b);
      assign st_space[gs] = cap_b - slots_r[gs];
      assign st_empty[gs] = (slots_r[gs] == '0);
      assign st_under[gs] = (stall_r2[gs] < STALL_W'(stall_r));
    end

    // One bid per port; ports past the port count never request.
    for (gp = 0; gp < MASK_BITS; gp++) begin : g_cand
      if (gp < PORT_LIMIT) begin : g_real
        logic [ST_W-1:0] st;
        assign st = station_of(map_r, PORT_W'(gp));
        assign cands[gp].req    = mask_r[gp];
        assign cands[gp].ok     = mask_r[gp] & st_ok[st];
        assign cands[gp].stall  = stall_r2[st];
        assign cands[gp].space  = st_space[st];
        assign cands[gp].weight = weight_r[gp];
        assign cands[gp].port   = PORT_W'(gp);
      end else begin : g_none
        assign cands[gp] = '0;
      end
    end
  endgenerate

  cpa_select u_select (
    .cands (cands),
    .pick  (pick)
  );

  // Decode the transaction and its checks.
  assign is_alloc = req_v_r && (kind_r == KIND_ALLOC);
  assign is_rel   = req_v_r && ((kind_r == KIND_ISSUE) || (kind_r == KIND_DEALLOC));
  assign is_tick  = req_v_r && (kind_r == KIND_TICK);
  assign best_st  = station_of(map_r, pick.best);
  assign tgt_st   = station_of(map_r, tgt_r);
  assign tgt_ok   = (32'(tgt_r) < PORT_LIMIT);
  assign alloc_go = is_alloc & pick.any;
  assign rel_err  = !tgt_ok || st_empty[tgt_st] || st_under[tgt_st];
  assign rel_go   = is_rel & ~rel_err;

  // Next station counters.
  always_comb begin
    logic [STALL_W:0] sum;
    for (int i = 0; i < NUM_STATIONS; i++) begin
      slots_nxt[i] = slots_r[i];
      stall_nxt[i] = stall_r2[i];
      disp_nxt[i]  = disp_r[i];
      sum = {1'b0, stall_r2[i]} + (STALL_W+1)'(stall_r);
      if (alloc_go && (best_st == ST_W'(i))) begin
        if (slots_r[i] != SLOT_MAX) slots_nxt[i] = slots_r[i] + 1'b1;
        if (disp_r[i] != SLOT_MAX)  disp_nxt[i]  = disp_r[i] + 1'b1;
        stall_nxt[i] = sum[STALL_W] ? STALL_MAX : sum[STALL_W-1:0];
      end
      if (rel_go && (tgt_st == ST_W'(i))) begin
        slots_nxt[i] = slots_r[i] - 1'b1;
        stall_nxt[i] = stall_r2[i] - STALL_W'(stall_r);
      end
      if (is_tick) begin
        disp_nxt[i] = '0;
      end
    end
  end

  // Next port weights; they wrap both ways.
  always_comb begin
    for (int i = 0; i < NUM_PORTS; i++) begin
      weight_nxt[i] = weight_r[i];
      if (alloc_go && (32'(pick.best) == i)) begin
        weight_nxt[i] = weight_r[i] + 1'b1;
      end
      if (rel_go && (kind_r == KIND_DEALLOC) && (32'(tgt_r) == i)) begin
        weight_nxt[i] = weight_r[i] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STATIONS; i++) begin
        slots_r[i]  <= '0;
        stall_r2[i] <= '0;
        disp_r[i]   <= '0;
      end
      for (int i = 0; i < NUM_PORTS; i++) begin
        weight_r[i] <= '0;
      end
    end else begin
      slots_r  <= slots_nxt;
      stall_r2 <= stall_nxt;
      disp_r   <= disp_nxt;
      weight_r <= weight_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= req_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_chosen_port <= alloc_go ? pick.best : '0;
    out_found_free  <= alloc_go & pick.have;
    out_error       <= (is_alloc & ~pick.any) | (is_rel & rel_err);
  end

endmodule
